FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle.
`define SRV_ASSERT_NOW(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Implication into the following cycle.
`define SRV_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: sv/srv_pkg.sv
// ---------------------------------------------------------------------------
// Scan repulsion vector package
// Sizes, fixed-point constants and the arctangent table of the CORDIC units.
// ---------------------------------------------------------------------------
package srv_pkg;

   localparam int SCAN_SAMPLES       = 512;
   localparam int TRIG_FRACTION_BITS = 15;
   localparam int ROT_STEPS          = TRIG_FRACTION_BITS + 4;
   localparam int VEC_STEPS          = 30;

   localparam int POS_W  = $clog2(SCAN_SAMPLES);
   localparam int REM_W  = POS_W + 1;
   localparam int TRIG_W = TRIG_FRACTION_BITS + 5;
   localparam int ANG_W  = 34;
   localparam int VEC_W  = 50;
   localparam int SUM_W  = 48;
   localparam int STEP_W = 5;
   localparam int PROD_W = 32 + TRIG_W;
   localparam int RAD_W  = 62;
   localparam int ROOT_W = 31;

   localparam longint ANG_STEP = (64'sd1 <<< 31) / SCAN_SAMPLES;
   localparam longint ANG_REM  = (64'sd1 <<< 31) % SCAN_SAMPLES;
   localparam longint TRIG_X0  =
      ((64'sd652032874 <<< TRIG_FRACTION_BITS) + (64'sd1 <<< 29)) >>> 30;
   localparam longint SUM_LIMIT = (64'sd1 <<< 47) - 64'sd1;

   localparam logic [15:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [29:0] MAG_MAX         = 30'h3FFF_FFFF;

   function automatic logic signed [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
      logic signed [ANG_W-1:0] v;
      case (k)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         5'd30: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/srv_isqrt.sv
// ---------------------------------------------------------------------------
// Integer square root
// Restoring square root that settles two radicand bits per cycle.
// ---------------------------------------------------------------------------
module srv_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srv_pkg::RAD_W-1:0]     radicand,
   output logic                          busy,
   output logic [srv_pkg::ROOT_W-1:0]    root
);
   import srv_pkg::*;

   logic             busy_ff;
   logic [RAD_W-1:0] rem_ff;
   logic [RAD_W-1:0] res_ff;
   logic [RAD_W-1:0] bit_ff;
   logic [RAD_W-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         rem_ff  <= radicand;
         res_ff  <= '0;
         bit_ff  <= RAD_W'(1) << (RAD_W - 2);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         if (bit_ff[1:0] != 2'b00) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy = busy_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

FILE: sv/scan_repulsion_vector_core.sv
// ---------------------------------------------------------------------------
// Scan repulsion vector core
// One beat is in flight at a time. A sample that adds no force does not leave the
// idle state; one that adds force runs the rotation CORDIC and multiply-accumulate.
// A scan_end beat runs the normalising shift and vectoring CORDIC, or for a zero
// sum waits only on the square root, and is further held for as long as an
// earlier result is still held. Reset clears the sums, sample position and
// pending result; the threshold returns to 1000.
// ---------------------------------------------------------------------------
module scan_repulsion_vector_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_range_mm,
   input  logic               req_range_invalid,
   input  logic               req_scan_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [29:0]        rsp_force_magnitude,
   output logic signed [11:0] rsp_force_bearing_decideg
);
   import srv_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ROT, S_MULX, S_ADDX, S_MULY, S_ADDY, S_SQX, S_SQY,
      S_SUMSQ, S_NORM, S_VEC, S_ANG, S_ROUND, S_FIN
   } state_type;

   state_type                 state_ff;
   logic [15:0]               thr_ff;
   logic signed [SUM_W-1:0]   sum_x_ff;
   logic signed [SUM_W-1:0]   sum_y_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [POS_W-1:0]          rem_ff;
   logic [31:0]               ang_ff;
   logic [15:0]               diff_ff;
   logic [31:0]               w_ff;
   logic signed [TRIG_W-1:0]  x_ff;
   logic signed [TRIG_W-1:0]  y_ff;
   logic signed [ANG_W-1:0]   z_ff;
   logic [STEP_W-1:0]         k_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [SUM_W-1:0]          abx_ff;
   logic [SUM_W-1:0]          aby_ff;
   logic                      negx_ff;
   logic                      negy_ff;
   logic                      big_ff;
   logic                      zero_ff;
   logic [59:0]               sqx_ff;
   logic [59:0]               sqy_ff;
   logic signed [VEC_W-1:0]   vx_ff;
   logic signed [VEC_W-1:0]   vy_ff;
   logic [46:0]               m_ff;
   logic                      aneg_ff;
   logic signed [11:0]        bear_ff;
   logic                      rsp_valid_ff;
   logic [29:0]               mag_ff;
   logic signed [11:0]        out_bear_ff;

   logic [SUM_W-1:0]          abs_x;
   logic [SUM_W-1:0]          abs_y;
   logic [REM_W-1:0]          rem_sum;
   logic                      rem_carry;
   logic signed [ANG_W-1:0]   z_start;
   logic signed [TRIG_W-1:0]  sh_x;
   logic signed [TRIG_W-1:0]  sh_y;
   logic signed [VEC_W-1:0]   vsh_x;
   logic signed [VEC_W-1:0]   vsh_y;
   logic [TRIG_W-1:0]         trig_mag;
   logic [PROD_W-1:0]         rounded;
   logic signed [SUM_W:0]     term;
   logic signed [SUM_W:0]     acc_sum;
   logic signed [SUM_W-1:0]   acc_sat;
   logic signed [ANG_W:0]     a_base;
   logic signed [ANG_W:0]     a_signed;
   logic [ANG_W:0]            a_abs;
   logic [14:0]               deg_mag;
   logic signed [15:0]        deg;
   logic signed [15:0]        wrap0;
   logic signed [15:0]        wrap1;
   logic                      sq_start;
   logic                      sq_busy;
   logic [ROOT_W-1:0]         sq_root;
   logic [29:0]               mag_value;
   logic                      active;
   logic                      rsp_load;

   srv_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (RAD_W'(sqx_ff) + RAD_W'(sqy_ff)),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   assign abs_x     = sum_x_ff[SUM_W-1] ? SUM_W'(-sum_x_ff) : SUM_W'(sum_x_ff);
   assign abs_y     = sum_y_ff[SUM_W-1] ? SUM_W'(-sum_y_ff) : SUM_W'(sum_y_ff);
   assign rem_sum   = REM_W'(rem_ff) + REM_W'(ANG_REM);
   assign rem_carry = rem_sum >= REM_W'(SCAN_SAMPLES);
   assign z_start   = $signed({2'b00, ang_ff}) - (ANG_W'(1) <<< 30);
   assign active    = !req_range_invalid && (req_range_mm < thr_ff);
   assign sq_start  = state_ff == S_SUMSQ;
   assign rsp_load  = (state_ff == S_FIN) && !sq_busy && (!rsp_valid_ff || !rsp_stall);

   assign sh_x  = x_ff >>> k_ff;
   assign sh_y  = y_ff >>> k_ff;
   assign vsh_x = vx_ff >>> k_ff;
   assign vsh_y = vy_ff >>> k_ff;

   always_comb begin
      logic signed [TRIG_W-1:0] t;
      t        = (state_ff == S_MULX) ? x_ff : y_ff;
      trig_mag = t[TRIG_W-1] ? TRIG_W'(-t) : TRIG_W'(t);
   end

   assign rounded = (prod_ff + (PROD_W'(1) << (TRIG_FRACTION_BITS - 1)))
                    >> TRIG_FRACTION_BITS;

   always_comb begin
      logic signed [SUM_W-1:0] base;
      logic                    neg;
      base    = (state_ff == S_ADDX) ? sum_x_ff : sum_y_ff;
      neg     = (state_ff == S_ADDX) ? x_ff[TRIG_W-1] : y_ff[TRIG_W-1];
      term    = neg ? -$signed({1'b0, SUM_W'(rounded)})
                    : $signed({1'b0, SUM_W'(rounded)});
      acc_sum = $signed({base[SUM_W-1], base}) + term;
      if (acc_sum > (SUM_W+1)'(SUM_LIMIT)) begin
         acc_sat = SUM_W'(SUM_LIMIT);
      end else if (acc_sum < -(SUM_W+1)'(SUM_LIMIT)) begin
         acc_sat = -SUM_W'(SUM_LIMIT);
      end else begin
         acc_sat = acc_sum[SUM_W-1:0];
      end
   end

   assign a_base   = negx_ff ? ((ANG_W+1)'(1) <<< 31) - (ANG_W+1)'(z_ff) : (ANG_W+1)'(z_ff);
   assign a_signed = negy_ff ? -a_base : a_base;
   assign a_abs    = a_signed[ANG_W] ? (ANG_W+1)'(-a_signed) : (ANG_W+1)'(a_signed);

   assign deg_mag = 15'((m_ff + (47'd1 << 31)) >> 32);
   assign deg     = aneg_ff ? -$signed({1'b0, deg_mag}) : $signed({1'b0, deg_mag});

   always_comb begin
      wrap0 = deg + 16'sd1800;
      if (wrap0 < 16'sd0) begin
         wrap0 = wrap0 + 16'sd3600;
      end
      wrap1 = wrap0;
      if (wrap1 >= 16'sd3600) begin
         wrap1 = wrap1 - 16'sd3600;
      end
      if (wrap1 >= 16'sd1800) begin
         wrap1 = wrap1 - 16'sd3600;
      end
   end

   assign mag_value = (big_ff || sq_root[ROOT_W-1]) ? MAG_MAX : sq_root[29:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         pos_ff       <= '0;
         rem_ff       <= '0;
         ang_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_scan_end) begin
                     abx_ff   <= abs_x;
                     aby_ff   <= abs_y;
                     negx_ff  <= sum_x_ff[SUM_W-1];
                     negy_ff  <= sum_y_ff[SUM_W-1];
                     big_ff   <= (abs_x[SUM_W-1:30] != '0) || (abs_y[SUM_W-1:30] != '0);
                     zero_ff  <= (abs_x == '0) && (abs_y == '0);
                     sum_x_ff <= '0;
                     sum_y_ff <= '0;
                     pos_ff   <= '0;
                     rem_ff   <= '0;
                     ang_ff   <= '0;
                     state_ff <= S_SQX;
                  end else begin
                     x_ff    <= TRIG_W'(TRIG_X0);
                     y_ff    <= '0;
                     z_ff    <= z_start;
                     k_ff    <= '0;
                     diff_ff <= thr_ff - req_range_mm;
                     if (pos_ff < POS_W'(SCAN_SAMPLES - 1)) begin
                        pos_ff <= pos_ff + 1'b1;
                        ang_ff <= ang_ff + 32'(ANG_STEP) + 32'(rem_carry);
                        rem_ff <= rem_carry ? POS_W'(rem_sum - REM_W'(SCAN_SAMPLES))
                                            : POS_W'(rem_sum);
                     end
                     if (active) begin
                        state_ff <= S_ROT;
                     end
                  end
               end
            end
            S_ROT: begin
               if (k_ff == '0) begin
                  w_ff <= diff_ff * diff_ff;
               end
               if (!z_ff[ANG_W-1]) begin
                  x_ff <= x_ff - sh_y;
                  y_ff <= y_ff + sh_x;
                  z_ff <= z_ff - atan_turn(k_ff);
               end else begin
                  x_ff <= x_ff + sh_y;
                  y_ff <= y_ff - sh_x;
                  z_ff <= z_ff + atan_turn(k_ff);
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == STEP_W'(ROT_STEPS - 1)) begin
                  state_ff <= S_MULX;
               end
            end
            S_MULX: begin
               prod_ff  <= PROD_W'(w_ff) * PROD_W'(trig_mag);
               state_ff <= S_ADDX;
            end
            S_ADDX: begin
               sum_x_ff <= acc_sat;
               state_ff <= S_MULY;
            end
            S_MULY: begin
               prod_ff  <= PROD_W'(w_ff) * PROD_W'(trig_mag);
               state_ff <= S_ADDY;
            end
            S_ADDY: begin
               sum_y_ff <= acc_sat;
               state_ff <= S_IDLE;
            end
            S_SQX: begin
               sqx_ff   <= abx_ff[29:0] * abx_ff[29:0];
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sqy_ff   <= aby_ff[29:0] * aby_ff[29:0];
               state_ff <= S_SUMSQ;
            end
            S_SUMSQ: begin
               vx_ff    <= VEC_W'(abx_ff);
               vy_ff    <= VEC_W'(aby_ff);
               z_ff     <= '0;
               k_ff     <= '0;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (zero_ff) begin
                  state_ff <= S_ANG;
               end else if (vx_ff < (VEC_W'(1) <<< 40) && vy_ff < (VEC_W'(1) <<< 40)) begin
                  vx_ff <= vx_ff <<< 1;
                  vy_ff <= vy_ff <<< 1;
               end else begin
                  state_ff <= S_VEC;
               end
            end
            S_VEC: begin
               if (vy_ff > 0) begin
                  vx_ff <= vx_ff + vsh_y;
                  vy_ff <= vy_ff - vsh_x;
                  z_ff  <= z_ff + atan_turn(k_ff);
               end else begin
                  vx_ff <= vx_ff - vsh_y;
                  vy_ff <= vy_ff + vsh_x;
                  z_ff  <= z_ff - atan_turn(k_ff);
               end
               k_ff <= k_ff + 1'b1;
               if (k_ff == STEP_W'(VEC_STEPS - 1)) begin
                  state_ff <= S_ANG;
               end
            end
            S_ANG: begin
               m_ff     <= 47'(a_abs) * 47'd3600;
               aneg_ff  <= a_signed[ANG_W];
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               bear_ff  <= wrap1[11:0];
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (rsp_load) begin
                  mag_ff      <= mag_value;
                  out_bear_ff <= bear_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall                 = state_ff != S_IDLE;
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_force_magnitude       = mag_ff;
   assign rsp_force_bearing_decideg = out_bear_ff;

endmodule

FILE: sv/srv_checker.sv
// ---------------------------------------------------------------------------
// Scan repulsion vector checker
// Port-level assertions on the request and result channels, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module srv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_scan_end,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [29:0]        rsp_force_magnitude,
   input logic signed [11:0] rsp_force_bearing_decideg
);

   // A result beat that is held back stays on offer.
   `SRV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")

   // A held result beat keeps its payload.
   `SRV_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_force_magnitude) && $stable(rsp_force_bearing_decideg), "result payload changed while stalled")

   // Only the last sample of a scan produces a result.
   `SRV_ASSERT_NEXT(a_no_spurious, req_valid && !req_stall && !req_scan_end, !$rose(rsp_valid), "result raised after a sample that is not the last")

   // The bearing is always wrapped into the half-open turn.
   `SRV_ASSERT_NOW(a_bearing_range, rsp_valid, (rsp_force_bearing_decideg >= -12'sd1800) && (rsp_force_bearing_decideg <= 12'sd1799), "bearing outside the wrapped range")

endmodule

bind scan_repulsion_vector_core srv_checker u_srv_checker (.*);
